/* hw/rtl/utf8_byte_sanitizer_unit_macros.svh */
// Assertion macros shared by the sanitizer RTL.
// Depends on nothing; modules using it provide clk and arst_n.
`ifndef UTF8_BYTE_SANITIZER_UNIT_MACROS_SVH
`define UTF8_BYTE_SANITIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define U8SAN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define U8SAN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define U8SAN_ASSERT_NOW(label, ante, cons, msg)
`define U8SAN_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* hw/rtl/u8san_pkg.sv */
// Types, constants and lead classification for the UTF-8 byte sanitizer.
// Depends on nothing.
package u8san_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int TOTAL_W     = 16;
	localparam int EXT_W       = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] DOT_CHAR  = 8'h2E;
	localparam logic [7:0] ASCII_TOP = 8'h7F;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		logic               out_last;
		logic [TOTAL_W-1:0] error_total;
	} result_t;

	// one request's worth of output bytes
	typedef struct packed {
		logic [3:0][7:0]    bytes;
		logic [1:0]         last_idx;
		logic               last;
		logic [TOTAL_W-1:0] error_total;
	} group_t;

	function automatic logic [1:0] lead_need(input logic [7:0] b);
		logic [1:0] n;
		n = 2'd0;
		if (b inside {[8'hC2:8'hDF]}) n = 2'd1;
		else if (b inside {[8'hE0:8'hEF]}) n = 2'd2;
		else if (b inside {[8'hF0:8'hF4]}) n = 2'd3;
		return n;
	endfunction

	function automatic logic [7:0] fix_cont(input logic [7:0] b);
		return {2'b10, b[5:0]};
	endfunction

	function automatic logic [TOTAL_W-1:0] to_total(input logic [COUNT_WIDTH-1:0] c);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(c);
		return ext[TOTAL_W-1:0];
	endfunction

endpackage

/* hw/rtl/utf8_byte_sanitizer_unit.sv */
// Top level of the UTF-8 byte sanitizer: front, group queue and back.
// Depends on u8san_pkg, u8san_front, u8san_queue, u8san_back.
//
// One input byte is taken per cycle while full is low. Each byte yields zero
// to four output bytes, grouped per request and kept in a four-group queue;
// the back end delivers one output byte per cycle while pop is high and the
// queue is not empty. Full rises only when the queue holds four undelivered
// groups. Each group is registered into the queue when its request is taken
// and is presented once the groups ahead of it have been delivered.
module utf8_byte_sanitizer_unit
	import u8san_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic   take;
	logic   grp_valid;
	group_t grp;
	group_t head;
	logic   q_rd;

	assign take = push && !full;

	u8san_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.grp_valid (grp_valid),
		.grp       (grp)
	);

	u8san_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take && grp_valid),
		.wr_data (grp),
		.rd      (q_rd),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	u8san_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (empty),
		.pop     (pop),
		.q_rd    (q_rd),
		.result  (result)
	);

endmodule

/* hw/rtl/u8san_queue.sv */
// Short group queue between the classifying front and the emitting back.
// Depends on u8san_pkg.
`include "utf8_byte_sanitizer_unit_macros.svh"

module u8san_queue
	import u8san_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  group_t wr_data,
	input  logic   rd,
	output group_t rd_data,
	output logic   full,
	output logic   empty
);

	group_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	`U8SAN_ASSERT_NOW(a_count_range, 1'b1, count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue overfilled")
	`U8SAN_ASSERT_NEXT(a_count_dec, do_rd && !do_wr, count_q == $past(count_q) - 1'b1, "pop lost")
	`U8SAN_ASSERT_NEXT(a_count_inc, do_wr && !do_rd, count_q == $past(count_q) + 1'b1, "push lost")

endmodule

/* hw/rtl/u8san_front.sv */
// Front end: classifies bytes, assembles sequences, counts errors.
// Depends on u8san_pkg.
`include "utf8_byte_sanitizer_unit_macros.svh"

module u8san_front
	import u8san_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   take,
	input  item_t  item,
	output logic   grp_valid,
	output group_t grp
);

	logic [3:0][7:0]        held_q;
	logic [1:0]             need_q;
	logic [1:0]             cnt_q;
	logic [COUNT_WIDTH-1:0] err_q;

	logic [7:0]             b;
	logic [1:0]             lead_n;
	logic [1:0]             cnt_nx;
	logic                   done;
	logic [1:0]             inc;
	logic [3:0][7:0]        seq;
	logic [COUNT_WIDTH:0]   sum;
	logic [COUNT_WIDTH-1:0] err_nx;

	assign b      = item.in_byte;
	assign lead_n = lead_need(b);
	assign cnt_nx = cnt_q + 1'b1;
	assign done   = (need_q != 2'd0) && (cnt_nx == need_q);

	always_comb begin
		seq = held_q;
		seq[cnt_nx] = b;
		inc = 2'd0;
		grp_valid = 1'b0;
		grp.bytes = {4{DOT_CHAR}};
		grp.last_idx = 2'd0;
		if (need_q == 2'd0) begin
			if (b <= ASCII_TOP) begin
				grp_valid = 1'b1;
				grp.bytes[0] = b;
			end else if (lead_n == 2'd0 || item.in_last) begin
				grp_valid = 1'b1;
				inc = 2'd1;
			end
		end else if (done) begin
			grp_valid = 1'b1;
			grp.last_idx = need_q;
			grp.bytes[0] = held_q[0];
			for (int i = 1; i < 4; i++) begin
				grp.bytes[i] = fix_cont(seq[i]);
				if (i <= int'(need_q) && seq[i][7:6] != 2'b10) inc = inc + 2'd1;
			end
		end else if (item.in_last) begin
			grp_valid = 1'b1;
			inc = 2'd1;
		end
		sum = {1'b0, err_q} + (COUNT_WIDTH+1)'(inc);
		err_nx = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
		grp.last = item.in_last;
		grp.error_total = to_total(err_nx);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (need_q == 2'd0) held_q[0] <= b;
			else held_q[cnt_nx] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= 2'd0;
			cnt_q  <= 2'd0;
			err_q  <= '0;
		end else if (take) begin
			if (item.in_last) begin
				need_q <= 2'd0;
				cnt_q  <= 2'd0;
				err_q  <= '0;
			end else begin
				err_q <= err_nx;
				if (need_q == 2'd0) begin
					need_q <= (b <= ASCII_TOP) ? 2'd0 : lead_n;
					cnt_q  <= 2'd0;
				end else if (done) begin
					need_q <= 2'd0;
					cnt_q  <= 2'd0;
				end else begin
					cnt_q <= cnt_nx;
				end
			end
		end
	end

	`U8SAN_ASSERT_NOW(a_idle_cnt, need_q == 2'd0, cnt_q == 2'd0, "count set with no open sequence")
	`U8SAN_ASSERT_NOW(a_cnt_below, need_q != 2'd0, cnt_q < need_q, "sequence overran")
	`U8SAN_ASSERT_NEXT(a_text_end, take && item.in_last, need_q == 2'd0 && err_q == '0,
		"state not cleared at end of text")
	`U8SAN_ASSERT_NOW(a_last_emits, take && item.in_last, grp_valid, "final byte gave no output")

endmodule

/* hw/rtl/u8san_back.sv */
// Back end: walks the head group of the queue and presents one byte at a time.
// Depends on u8san_pkg.
module u8san_back
	import u8san_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  group_t  head,
	input  logic    q_empty,
	input  logic    pop,
	output logic    q_rd,
	output result_t result
);

	logic [1:0] idx_q;
	logic       at_end;

	assign at_end = (idx_q == head.last_idx);
	assign q_rd   = pop && !q_empty && at_end;

	assign result.out_byte    = head.bytes[idx_q];
	assign result.out_last    = head.last && at_end;
	assign result.error_total = head.error_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (pop && !q_empty) begin
			idx_q <= at_end ? 2'd0 : idx_q + 1'b1;
		end
	end

endmodule

/* dv/utf8_sanitizer_checker.sv */
`timescale 1ns / 100ps
// Checker for the UTF-8 byte sanitizer: watches both queue ports, predicts the
// output bytes of every accepted request and compares them in order.
// Depends on u8san_pkg.
module utf8_sanitizer_checker
	import u8san_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    full,
	input  item_t   item,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      fail_total,
	output int      outstanding
);

	localparam int MAX_REPORTS = 10;

	result_t                expected_bytes[$];
	logic [7:0]             seq_bytes [4];
	logic [1:0]             seq_need;
	logic [1:0]             seq_got;
	logic [COUNT_WIDTH-1:0] text_errors;
	int                     fails;

	function automatic void count_error();
		if (text_errors != COUNT_MAX) text_errors = text_errors + 1'b1;
	endfunction

	task automatic sanitize_request(input item_t req);
		logic [7:0] grp[$];
		logic [7:0] b;
		logic [7:0] fixed;
		logic [1:0] need;
		result_t    r;
		b = req.in_byte;
		if (seq_need == 2'd0) begin
			if (b >= 8'hC2 && b <= 8'hDF) need = 2'd1;
			else if (b >= 8'hE0 && b <= 8'hEF) need = 2'd2;
			else if (b >= 8'hF0 && b <= 8'hF4) need = 2'd3;
			else need = 2'd0;
			if (b <= ASCII_TOP) begin
				grp.push_back(b);
			end else if (need == 2'd0 || req.in_last) begin
				count_error();
				grp.push_back(DOT_CHAR);
			end else begin
				seq_bytes[0] = b;
				seq_need = need;
				seq_got = 2'd0;
			end
		end else begin
			seq_got = seq_got + 2'd1;
			seq_bytes[seq_got] = b;
			if (seq_got == seq_need) begin
				grp.push_back(seq_bytes[0]);
				for (int i = 1; i <= seq_need; i++) begin
					fixed = {2'b10, seq_bytes[i][5:0]};
					if (fixed != seq_bytes[i]) count_error();
					grp.push_back(fixed);
				end
				seq_need = 2'd0;
				seq_got = 2'd0;
			end else if (req.in_last) begin
				// cut-off: held continuations add no errors of their own
				count_error();
				grp.push_back(DOT_CHAR);
				seq_need = 2'd0;
				seq_got = 2'd0;
			end
		end
		for (int k = 0; k < grp.size(); k++) begin
			r.out_byte = grp[k];
			r.out_last = req.in_last && (k == grp.size() - 1);
			r.error_total = TOTAL_W'(text_errors);
			expected_bytes.push_back(r);
		end
		if (req.in_last) begin
			text_errors = '0;
			seq_need = 2'd0;
			seq_got = 2'd0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			seq_need = 2'd0;
			seq_got = 2'd0;
			text_errors = '0;
			fails = 0;
			outstanding <= 0;
			fail_total <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("%0t: unexpected output byte %02h last %0b errors %0d",
							$realtime, result.out_byte, result.out_last, result.error_total);
				end else begin
					want = expected_bytes.pop_front();
					if (result.out_byte !== want.out_byte || result.out_last !== want.out_last ||
						result.error_total !== want.error_total) begin
						fails++;
						if (fails <= MAX_REPORTS)
							$display("%0t: mismatch: expected byte %02h last %0b errors %0d, got byte %02h last %0b errors %0d",
								$realtime, want.out_byte, want.out_last, want.error_total,
								result.out_byte, result.out_last, result.error_total);
					end
				end
			end
			if (push && !full) sanitize_request(item);
			outstanding <= expected_bytes.size();
			fail_total <= fails;
		end
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Top of the UTF-8 byte sanitizer testbench: clock, reset, request stimulus
// and result draining. Depends on u8san_pkg, utf8_byte_sanitizer_unit and
// utf8_sanitizer_checker.
module tb;
	import u8san_pkg::*;

	localparam int RANDOM_REQS  = 380;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int IDLE_PERCENT = 31;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	item_t   item = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t result;
	int      fail_total;
	int      outstanding;

	logic    calm = 1'b0;
	logic    hold_req = 1'b0;
	int      cycle_count = 0;

	// bit 8 marks the final byte of a text
	logic [8:0] directed_reqs [27] = '{
		9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0DF, 9'h0FF, 9'h0E0, 9'h000, 9'h0C0,
		9'h080, 9'h0C1, 9'h0F5, 9'h0FF, 9'h0EF, 9'h0BF, 9'h0BF, 9'h0F4, 9'h08F,
		9'h0BF, 9'h1BF, 9'h0E0, 9'h100, 9'h1C2, 9'h0F0, 9'h080, 9'h180, 9'h17F
	};

	always #4 clk = ~clk;

	utf8_byte_sanitizer_unit u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	utf8_sanitizer_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.fail_total (fail_total),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic offer_byte(input logic [7:0] b, input logic l);
		while (!calm && $urandom_range(99, 0) < IDLE_PERCENT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= '{in_byte: b, in_last: l};
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] random_lead(input int need);
		case (need)
			1: return 8'($urandom_range(8'hDF, 8'hC2));
			2: return 8'($urandom_range(8'hEF, 8'hE0));
			3: return 8'($urandom_range(8'hF4, 8'hF0));
			default: return 8'($urandom_range(8'h7F, 8'h00));
		endcase
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				pop <= 1'b0;
			end else begin
				pop <= calm || $urandom_range(99, 0) >= IDLE_PERCENT;
			end
		end
	end

	initial begin
		logic [7:0] text[$];
		int         sent;
		int         units;
		int         kind;
		int         need;
		int         conts;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_reqs[i]) offer_byte(directed_reqs[i][7:0], directed_reqs[i][8]);

		hold_req = 1'b1;
		sent = 0;
		while (sent < RANDOM_REQS) begin
			text.delete();
			units = $urandom_range(10, 1);
			for (int u = 0; u < units; u++) begin
				kind = $urandom_range(99, 0);
				need = $urandom_range(3, 0);
				if (kind < 55) begin
					text.push_back(random_lead(need));
					repeat (need) text.push_back({2'b10, 6'($urandom_range(63, 0))});
				end else if (kind < 70) begin
					text.push_back(8'($urandom_range(255, 0)));
				end else if (kind < 85) begin
					text.push_back(random_lead(need));
					repeat (need) text.push_back(8'($urandom_range(255, 0)));
				end else begin
					// sequence left short
					if (need == 0) need = 1;
					conts = $urandom_range(need - 1, 0);
					text.push_back(random_lead(need));
					repeat (conts) text.push_back(8'($urandom_range(255, 0)));
				end
			end
			foreach (text[i]) begin
				calm = (sent >= 140 && sent < 260);
				offer_byte(text[i], i == text.size() - 1);
				sent++;
			end
		end

		calm = 1'b0;
		push <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_total == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
